### sv/crsm_pkg.sv
package crsm_pkg;

  localparam logic [1:0] CMD_STORE_CHAR = 2'd0;
  localparam logic [1:0] CMD_SET_LEN    = 2'd1;
  localparam logic [1:0] CMD_QUERY_CHAR = 2'd2;
  localparam logic [1:0] CMD_NOP        = 2'd3;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;

  function automatic logic is_base(input logic [7:0] c);
    return (c == CH_A) || (c == CH_C) || (c == CH_G) || (c == CH_T);
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic rec_setup;
    logic chr_next;
    logic rec_next;
    logic rot_next;
    logic mark_hit;
    logic res_load;
  } crsm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic search_go;
    logic len_hit;
    logic chr_eq;
    logic chr_last;
    logic rec_first;
    logic rot_last;
  } crsm_stat_t;

endpackage

### sv/crsm_ctrl.sv
module crsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crsm_pkg::crsm_stat_t stat,
  output crsm_pkg::crsm_cmd_t  cmd
);
  import crsm_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_LCHK  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] miss_state;
  logic       miss_rec_next;
  logic       miss_rot_next;

  // Moving on after a record fails: next lower record, else next rotation, else give up.
  always_comb begin
    miss_rec_next = 1'b0;
    miss_rot_next = 1'b0;
    miss_state    = S_LEN;
    if (!stat.rec_first) begin
      miss_rec_next = 1'b1;
    end else if (!stat.rot_last) begin
      miss_rot_next = 1'b1;
    end else begin
      miss_state = S_DONE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (cmd.accept && stat.search_go) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.rec_setup = 1'b1;
        state_nxt     = S_LCHK;
      end
      S_LCHK: begin
        if (stat.len_hit) begin
          state_nxt = S_CMP;
        end else begin
          cmd.rec_next = miss_rec_next;
          cmd.rot_next = miss_rot_next;
          state_nxt    = miss_state;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.chr_eq && stat.chr_last) begin
          cmd.mark_hit = 1'b1;
          state_nxt    = S_DONE;
        end else if (stat.chr_eq) begin
          cmd.chr_next = 1'b1;
          state_nxt    = S_RD;
        end else begin
          cmd.rec_next = miss_rec_next;
          cmd.rot_next = miss_rot_next;
          state_nxt    = miss_state;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/crsm_dp.sv
module crsm_dp #(
  parameter int MAX_RECORDS = 8,
  parameter int MAX_LEN     = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crsm_pkg::crsm_cmd_t  cmd,
  output crsm_pkg::crsm_stat_t stat,
  input  logic [1:0]           in_cmd,
  input  logic [2:0]           in_record_slot,
  input  logic [3:0]           in_char_position,
  input  logic [7:0]           in_char_value,
  input  logic [4:0]           in_record_length,
  input  logic                 in_query_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_match_status,
  output logic [2:0]           out_matched_record,
  output logic [3:0]           out_rotation_amount
);
  import crsm_pkg::*;

  localparam int DEPTH    = MAX_RECORDS * MAX_LEN;
  localparam int RW       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int IW       = $clog2(MAX_LEN);
  localparam int LW       = $clog2(MAX_LEN + 1);
  localparam int AW       = $clog2(DEPTH);
  localparam int TOP_BASE = (MAX_RECORDS - 1) * MAX_LEN;

  // Storage.
  logic [7:0]    chr_mem [DEPTH];
  logic [LW-1:0] len_mem [MAX_RECORDS];
  logic [7:0]    qry_mem [MAX_LEN];

  logic [7:0]    chr_q_r;
  logic [7:0]    qry_q_r;
  logic [LW-1:0] len_q_r;

  // Query collection.
  logic [LW-1:0] count_r;
  logic          bad_r;
  logic          ovf_r;
  logic          full;
  logic          bad_now;
  logic          ovf_now;
  logic          is_query;
  logic          query_end;

  // Search counters.
  logic [RW-1:0] clr_idx_r;
  logic [LW-1:0] n_r;
  logic [RW-1:0] j_r;
  logic [AW-1:0] base_r;
  logic [IW-1:0] r_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] src_r;
  logic          hit_r;

  // Memory write ports.
  logic          chr_we;
  logic [AW-1:0] chr_waddr;
  logic          len_we;
  logic [RW-1:0] len_waddr;
  logic [LW-1:0] len_wdata;
  logic          qry_we;

  // Result register.
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [2:0]    out_rec_r;
  logic [3:0]    out_rot_r;
  logic          err_load;

  assign is_query  = (in_cmd == CMD_QUERY_CHAR);
  assign query_end = is_query && in_query_last;
  assign full      = (count_r == LW'(MAX_LEN));
  assign bad_now   = bad_r || !is_base(in_char_value);
  assign ovf_now   = ovf_r || full;
  assign err_load  = cmd.accept && query_end && (ovf_now || bad_now);

  always_comb begin
    chr_we    = 1'b0;
    len_we    = 1'b0;
    qry_we    = 1'b0;
    chr_waddr = AW'(32'(in_record_slot) * MAX_LEN + 32'(in_char_position));
    len_waddr = RW'(in_record_slot);
    len_wdata = (32'(in_record_length) > MAX_LEN) ? LW'(MAX_LEN) : LW'(in_record_length);
    if (cmd.clr_wr) begin
      len_we    = 1'b1;
      len_waddr = clr_idx_r;
      len_wdata = '0;
    end else if (cmd.accept) begin
      unique case (in_cmd)
        CMD_STORE_CHAR: chr_we = (32'(in_record_slot) < MAX_RECORDS) &&
                                 (32'(in_char_position) < MAX_LEN);
        CMD_SET_LEN:    len_we = (32'(in_record_slot) < MAX_RECORDS);
        CMD_QUERY_CHAR: qry_we = !full;
        CMD_NOP:        chr_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (chr_we) begin
      chr_mem[chr_waddr] <= in_char_value;
    end
    chr_q_r <= chr_mem[base_r + AW'(i_r)];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_q_r <= len_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (qry_we) begin
      qry_mem[IW'(count_r)] <= in_char_value;
    end
    qry_q_r <= qry_mem[src_r];
  end

  // Query collection and the length-memory clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      bad_r     <= 1'b0;
      ovf_r     <= 1'b0;
      clr_idx_r <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_idx_r <= clr_idx_r + RW'(1);
      end
      if (cmd.accept && is_query) begin
        if (in_query_last) begin
          count_r <= '0;
          bad_r   <= 1'b0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= full ? count_r : count_r + LW'(1);
          bad_r   <= bad_now;
          ovf_r   <= ovf_now;
        end
      end
    end
  end

  // Search walk: rotations outermost, records from the highest index down,
  // characters innermost; the query index follows (i - r) mod n.
  always_ff @(posedge clk) begin
    if (cmd.accept && query_end) begin
      n_r    <= count_r + LW'(1);
      j_r    <= RW'(MAX_RECORDS - 1);
      base_r <= AW'(TOP_BASE);
      r_r    <= '0;
    end
    if (cmd.rec_setup) begin
      i_r   <= '0;
      src_r <= (r_r == '0) ? '0 : IW'(n_r - LW'(r_r));
    end
    if (cmd.chr_next) begin
      i_r   <= i_r + IW'(1);
      src_r <= (LW'(src_r) == n_r - LW'(1)) ? '0 : src_r + IW'(1);
    end
    if (cmd.rec_next) begin
      j_r    <= j_r - RW'(1);
      base_r <= base_r - AW'(MAX_LEN);
    end
    if (cmd.rot_next) begin
      r_r    <= r_r + IW'(1);
      j_r    <= RW'(MAX_RECORDS - 1);
      base_r <= AW'(TOP_BASE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.accept && query_end) begin
      hit_r <= 1'b0;
    end else if (cmd.mark_hit) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (err_load || cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (err_load) begin
      out_status_r <= ovf_now ? ST_TOO_LONG : ST_INVALID;
      out_rec_r    <= '0;
      out_rot_r    <= '0;
    end else if (cmd.res_load) begin
      out_status_r <= hit_r ? ST_FOUND : ST_NOT_FOUND;
      out_rec_r    <= hit_r ? 3'(j_r) : '0;
      out_rot_r    <= hit_r ? 4'(r_r) : '0;
    end
  end

  assign stat.clr_last  = (clr_idx_r == RW'(MAX_RECORDS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.search_go = query_end && !ovf_now && !bad_now;
  assign stat.len_hit   = (len_q_r == n_r);
  assign stat.chr_eq    = (chr_q_r == qry_q_r);
  assign stat.chr_last  = (LW'(i_r) == n_r - LW'(1));
  assign stat.rec_first = (j_r == '0);
  assign stat.rot_last  = (LW'(r_r) == n_r - LW'(1));

  assign out_valid           = out_valid_r;
  assign out_match_status    = out_status_r;
  assign out_matched_record  = out_rec_r;
  assign out_rotation_amount = out_rot_r;

endmodule

### sv/cyclic_rotation_sequence_match.sv
// Cyclic rotation match of a DNA query against a small table of records.
// Input channel (in_valid/in_ready): each request is a record character
// store, a record length set, or one query character; the query character
// flagged by in_query_last ends the query and starts the search.
// Result channel (out_valid/out_ready): one result per finished query,
// giving status, the lowest rotation that hits and the highest record
// matching at that rotation. Loads and query characters are taken while
// the block is idle. A query that is too long or holds a non-ACGT character
// reports in the cycle after its last request. Otherwise the search walks
// rotations, then records from the highest index down, one character
// compare at a time through the registered reads of the record and query
// memories: each record has its length checked (S_LEN, S_LCHK), then its
// characters are compared in turn (S_RD, S_CMP); the result loads in S_DONE.
// After reset the block clears its record length memory, one record per
// cycle until all MAX_RECORDS entries are cleared, with in_ready low.
// The result sits in an output register; while a result waits unread, no
// request is taken unless the register frees up in the same cycle,
// and a search that finishes waits for the register.
module cyclic_rotation_sequence_match #(
  parameter int MAX_RECORDS = 8,
  parameter int MAX_LEN     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [2:0] in_record_slot,
  input  logic [3:0] in_char_position,
  input  logic [7:0] in_char_value,
  input  logic [4:0] in_record_length,
  input  logic       in_query_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_match_status,
  output logic [2:0] out_matched_record,
  output logic [3:0] out_rotation_amount
);
  import crsm_pkg::*;

  crsm_cmd_t  cmd;
  crsm_stat_t stat;

  crsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crsm_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .MAX_LEN     (MAX_LEN)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_cmd              (in_cmd),
    .in_record_slot      (in_record_slot),
    .in_char_position    (in_char_position),
    .in_char_value       (in_char_value),
    .in_record_length    (in_record_length),
    .in_query_last       (in_query_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_match_status    (out_match_status),
    .out_matched_record  (out_matched_record),
    .out_rotation_amount (out_rotation_amount)
  );

endmodule

### sv/crsm_check.sv
module crsm_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_cmd,
  input logic [7:0] in_char_value,
  input logic       in_query_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_match_status,
  input logic [2:0] out_matched_record,
  input logic [3:0] out_rotation_amount
);
  import crsm_pkg::*;

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_status) &&
      $stable(out_matched_record) && $stable(out_rotation_amount))
    else $error("result changed while stalled");

  // Only a found result carries a record index and a rotation.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_status != ST_FOUND |->
      out_matched_record == 3'd0 && out_rotation_amount == 4'd0)
    else $error("non-found result with nonzero record or rotation");

  // The length memory is being cleared right after reset.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken during the post-reset clear");

  // A final query character that is not a base gives an error result at once.
  a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_QUERY_CHAR && in_query_last &&
      !is_base(in_char_value) |=>
      out_valid && (out_match_status == ST_INVALID || out_match_status == ST_TOO_LONG))
    else $error("bad query did not report an error in the next cycle");

endmodule

bind cyclic_rotation_sequence_match crsm_check u_crsm_check (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_cmd              (in_cmd),
  .in_char_value       (in_char_value),
  .in_query_last       (in_query_last),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_match_status    (out_match_status),
  .out_matched_record  (out_matched_record),
  .out_rotation_amount (out_rotation_amount)
);

### dv/crsm_checker.sv
`timescale 1ns / 1ps

module crsm_checker #(
  parameter int MAX_RECORDS = 8,
  parameter int MAX_LEN     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [2:0] in_record_slot,
  input  logic [3:0] in_char_position,
  input  logic [7:0] in_char_value,
  input  logic [4:0] in_record_length,
  input  logic       in_query_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_match_status,
  input  logic [2:0] out_matched_record,
  input  logic [3:0] out_rotation_amount,
  output int         mismatch_count,
  output int         open_queries
);
  import crsm_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] rec;
    logic [3:0] rot;
  } match_result_t;

  logic [7:0]    rec_chars [MAX_RECORDS][MAX_LEN];
  logic [4:0]    rec_len [MAX_RECORDS];
  logic [7:0]    qry_chars [MAX_LEN];
  int            qry_count;
  bit            qry_bad;
  bit            qry_over;
  match_result_t expected_matches [$];

  // Rotations are tried in order; within one rotation every record is
  // compared, so the highest-indexed hit is the one that stands.
  function automatic match_result_t search_rotations();
    match_result_t m;
    int            n;
    int            src;
    bit            hit;
    bit            same;
    m        = '0;
    m.status = ST_NOT_FOUND;
    n        = qry_count;
    hit      = 1'b0;
    for (int r = 0; r < n && !hit; r++) begin
      for (int j = 0; j < MAX_RECORDS; j++) begin
        if (rec_len[j] == n) begin
          same = 1'b1;
          for (int i = 0; i < n; i++) begin
            src = (i >= r) ? (i - r) : (i + n - r);
            if (rec_chars[j][i] != qry_chars[src]) same = 1'b0;
          end
          if (same) begin
            hit   = 1'b1;
            m.rec = 3'(j);
            m.rot = 4'(r);
          end
        end
      end
    end
    if (hit) m.status = ST_FOUND;
    return m;
  endfunction

  task automatic take_request();
    match_result_t m;
    m = '0;
    if (in_cmd == CMD_STORE_CHAR) begin
      if (in_record_slot < MAX_RECORDS && in_char_position < MAX_LEN)
        rec_chars[in_record_slot][in_char_position] = in_char_value;
    end else if (in_cmd == CMD_SET_LEN) begin
      if (in_record_slot < MAX_RECORDS)
        rec_len[in_record_slot] = (in_record_length > MAX_LEN) ? 5'(MAX_LEN) :
                                  in_record_length;
    end else if (in_cmd == CMD_QUERY_CHAR) begin
      if (!(in_char_value == CH_A || in_char_value == CH_C ||
            in_char_value == CH_G || in_char_value == CH_T))
        qry_bad = 1'b1;
      if (qry_count < MAX_LEN) begin
        qry_chars[qry_count] = in_char_value;
        qry_count++;
      end else begin
        qry_over = 1'b1;
      end
      if (in_query_last) begin
        if (qry_over) m.status = ST_TOO_LONG;
        else if (qry_bad) m.status = ST_INVALID;
        else m = search_rotations();
        expected_matches.push_back(m);
        qry_count = 0;
        qry_bad   = 1'b0;
        qry_over  = 1'b0;
      end
    end
  endtask

  task automatic check_result();
    match_result_t m;
    if (expected_matches.size() == 0) begin
      $display("%0t: unexpected result, expected none, got status %0d record %0d rotation %0d",
               $time, out_match_status, out_matched_record, out_rotation_amount);
      mismatch_count++;
    end else begin
      m = expected_matches.pop_front();
      if (out_match_status !== m.status) begin
        $display("%0t: match_status expected %0d, got %0d", $time, m.status, out_match_status);
        mismatch_count++;
      end
      if (out_matched_record !== m.rec) begin
        $display("%0t: matched_record expected %0d, got %0d", $time, m.rec,
                 out_matched_record);
        mismatch_count++;
      end
      if (out_rotation_amount !== m.rot) begin
        $display("%0t: rotation_amount expected %0d, got %0d", $time, m.rot,
                 out_rotation_amount);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_RECORDS; j++) rec_len[j] = '0;
      qry_count      = 0;
      qry_bad        = 1'b0;
      qry_over       = 1'b0;
      mismatch_count = 0;
      expected_matches.delete();
    end else begin
      // The result is checked before the request of the same edge is taken,
      // so a result can never pair with a query that ends at that edge.
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_request();
    end
    open_queries = expected_matches.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import crsm_pkg::*;

  localparam int NUM_REC  = 8;
  localparam int REC_LEN  = 16;
  localparam int LONG_HOLD = 600;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd = CMD_NOP;
  logic [2:0] in_record_slot = '0;
  logic [3:0] in_char_position = '0;
  logic [7:0] in_char_value = '0;
  logic [4:0] in_record_length = '0;
  logic       in_query_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_match_status;
  logic [2:0] out_matched_record;
  logic [3:0] out_rotation_amount;
  int         mismatch_count;
  int         open_queries;

  int         send_idle_pct = 13;
  int         recv_idle_pct = 54;
  bit         hold_req = 1'b0;
  int         items_sent = 0;

  // What has been loaded into the table, used to build rotated queries and to copy a record.
  logic [7:0] shadow_chars [NUM_REC][REC_LEN];
  int         shadow_len [NUM_REC];
  logic [7:0] qv [0:19];

  always #5 clk = ~clk;

  cyclic_rotation_sequence_match #(
    .MAX_RECORDS(NUM_REC),
    .MAX_LEN    (REC_LEN)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_record_slot     (in_record_slot),
    .in_char_position   (in_char_position),
    .in_char_value      (in_char_value),
    .in_record_length   (in_record_length),
    .in_query_last      (in_query_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_match_status   (out_match_status),
    .out_matched_record (out_matched_record),
    .out_rotation_amount(out_rotation_amount)
  );

  crsm_checker #(
    .MAX_RECORDS(NUM_REC),
    .MAX_LEN    (REC_LEN)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_record_slot     (in_record_slot),
    .in_char_position   (in_char_position),
    .in_char_value      (in_char_value),
    .in_record_length   (in_record_length),
    .in_query_last      (in_query_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_match_status   (out_match_status),
    .out_matched_record (out_matched_record),
    .out_rotation_amount(out_rotation_amount),
    .mismatch_count     (mismatch_count),
    .open_queries       (open_queries)
  );

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [2:0] slot,
                          input logic [3:0] pos, input logic [7:0] ch,
                          input logic [4:0] len, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_record_slot   <= slot;
    in_char_position <= pos;
    in_char_value    <= ch;
    in_record_length <= len;
    in_query_last    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] random_base();
    case ($urandom_range(3))
      0:       return CH_A;
      1:       return CH_C;
      2:       return CH_G;
      default: return CH_T;
    endcase
  endfunction

  task automatic store_char(input int slot, input int pos, input logic [7:0] ch);
    send_req(CMD_STORE_CHAR, 3'(slot), 4'(pos), ch, 5'($urandom_range(31)),
             1'($urandom_range(1)));
    shadow_chars[slot][pos] = ch;
  endtask

  task automatic set_length(input int slot, input logic [4:0] len);
    send_req(CMD_SET_LEN, 3'(slot), 4'($urandom_range(15)), 8'($urandom_range(255)), len,
             1'($urandom_range(1)));
    shadow_len[slot] = (len > REC_LEN) ? REC_LEN : len;
  endtask

  task automatic query_char(input logic [7:0] ch, input logic last);
    send_req(CMD_QUERY_CHAR, 3'($urandom_range(7)), 4'($urandom_range(15)), ch,
             5'($urandom_range(31)), last);
  endtask

  task automatic send_nop();
    send_req(CMD_NOP, 3'($urandom_range(7)), 4'($urandom_range(15)),
             8'($urandom_range(255)), 5'($urandom_range(31)), 1'($urandom_range(1)));
  endtask

  task automatic load_record(input int slot, input int n);
    for (int i = 0; i < n; i++) store_char(slot, i, random_base());
    // A full-length record is sometimes given an oversize length.
    if (n == REC_LEN && $urandom_range(1) == 1) set_length(slot, 5'($urandom_range(16, 31)));
    else set_length(slot, 5'(n));
  endtask

  // Loads and no-ops may arrive between the characters of a query.
  task automatic stream_query(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0:       send_nop();
          1:       store_char($urandom_range(7), $urandom_range(15), random_base());
          default: set_length($urandom_range(7), 5'($urandom_range(6)));
        endcase
      end
      query_char(qv[k], k == n - 1);
    end
  endtask

  task automatic query_rotation(input int slot);
    int n;
    int r;
    int k;
    n = shadow_len[slot];
    r = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) qv[i] = shadow_chars[slot][(i + r) % n];
    if ($urandom_range(99) < 20) begin
      k = $urandom_range(n - 1);
      qv[k] = ($urandom_range(99) < 60) ? random_base() : 8'($urandom_range(255));
    end
    stream_query(n);
  endtask

  task automatic random_query(input int n);
    for (int i = 0; i < n; i++)
      qv[i] = ($urandom_range(99) < 95) ? random_base() : 8'($urandom_range(255));
    stream_query(n);
  endtask

  task automatic random_sequence();
    int pick;
    int slot;
    int start;
    pick = $urandom_range(99);
    if (pick < 25) begin
      load_record($urandom_range(7),
                  ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6));
    end else if (pick < 70) begin
      slot  = -1;
      start = $urandom_range(7);
      for (int i = 0; i < NUM_REC; i++)
        if (slot < 0 && shadow_len[(start + i) % NUM_REC] != 0) slot = (start + i) % NUM_REC;
      if (slot < 0) random_query($urandom_range(1, 6));
      else query_rotation(slot);
    end else if (pick < 85) begin
      random_query($urandom_range(1, 6));
    end else if (pick < 90) begin
      random_query($urandom_range(17, 20));
    end else begin
      case ($urandom_range(2))
        0:       send_nop();
        1:       store_char($urandom_range(7), $urandom_range(15), 8'($urandom_range(255)));
        default: set_length($urandom_range(7),
                            5'(($urandom_range(3) == 0) ? $urandom_range(31) :
                                                          $urandom_range(6)));
      endcase
    end
  endtask

  // Holds the input off until every outstanding query has reported.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_queries != 0) @(posedge clk);
  endtask

  initial begin
    int goal;
    for (int s = 0; s < NUM_REC; s++) shadow_len[s] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Queries against an empty table: a single base, then one with a bad byte.
    query_char(CH_A, 1'b1);
    query_char(CH_G, 1'b0);
    query_char(8'h80, 1'b1);
    send_nop();

    // Fill the whole table so that no search ever reads an unwritten byte.
    for (int s = 0; s < NUM_REC; s++)
      for (int p = 0; p < REC_LEN; p++) store_char(s, p, random_base());

    load_record(3, 4);
    query_rotation(3);
    // An identical record at a higher slot must win.
    for (int p = 0; p < 4; p++) store_char(5, p, shadow_chars[3][p]);
    set_length(5, 5'd4);
    query_rotation(3);
    set_length(5, 5'd0);
    set_length(3, 5'd0);
    wait_results_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      goal = items_sent + 500;
      while (items_sent < goal) random_sequence();
      wait_results_drained();
    end

    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && open_queries == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule
